// ===== src/utd_pkg.sv =====
// Shared constants, types and helpers for the unsigned-to-base-digits unit.
// Depends on nothing; the datapath, controller, top level and checker import it.
package utd_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int IN_BITS     = 64;
  localparam int CHUNK       = 8;
  localparam int STEPS       = (VALUE_BITS + CHUNK - 1) / CHUNK;
  localparam int REG_BITS    = STEPS * CHUNK;
  localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int MAX_DIGITS  = VALUE_BITS;
  localparam int DIG_AW      = $clog2(MAX_DIGITS);
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              first;
    logic              wr_en;
    logic [DIG_AW-1:0] wr_addr;
    logic              rd_en;
    logic [DIG_AW-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
  } sts_t;

  // Clamp a written radix into the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

  // Map a digit to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_LOWER_A + CHAR_W'(d - 4'd10);
  endfunction

endpackage

// ===== src/utd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module utd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/utd_datapath.sv =====
// Datapath: radix register, chunked divide-by-radix unit and digit store.
// Depends on utd_pkg and utd_ram.
module utd_datapath
  import utd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RADIX_W-1:0]  cfg_data_i,
  input  logic [IN_BITS-1:0]  value_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [CHAR_W-1:0]   digit_char_o
);

  logic [RADIX_W-1:0]  radix_q;
  logic [REG_BITS-1:0] value_q, value_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic                qnz_q, qnz_d;
  logic [CHUNK-1:0]    qbits;
  logic [DIGIT_W-1:0]  rdata;

  // Radix is configuration state: clamp on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= clamp_radix(cfg_data_i);
    end
  end

  // One chunk of restoring division: remainder stays below the radix.
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [RADIX_W-1:0] t;
    logic [CHUNK-1:0]   chunk;
    r     = cmd_i.first ? '0 : rem_q;
    chunk = value_q[REG_BITS-1 -: CHUNK];
    qbits = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {r, chunk[i]};
      if (t >= radix_q) begin
        r        = DIGIT_W'(t - radix_q);
        qbits[i] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    rem_d   = r;
    value_d = (value_q << CHUNK) | REG_BITS'(qbits);
    qnz_d   = (cmd_i.first ? 1'b0 : qnz_q) | (|qbits);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= REG_BITS'(value_i[VALUE_BITS-1:0]);
    end else if (cmd_i.step) begin
      value_q <= value_d;
      rem_q   <= rem_d;
      qnz_q   <= qnz_d;
    end
  end

  assign sts_o.quot_zero = !qnz_d;

  utd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (rem_d),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign digit_char_o = digit_char(rdata);

endmodule

// ===== src/utd_ctrl.sv =====
// Controller: sequences the chunk steps per digit, then reads the digits back
// most significant first. Depends on utd_pkg.
module utd_ctrl
  import utd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic out_strobe_o,
  output logic last_digit_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [DIG_AW-1:0] cnt_q;
  logic [DIG_AW-1:0] idx_q;
  logic              out_valid_q;
  logic              out_last_q;
  logic              last_step;

  assign busy      = (state_q != ST_IDLE);
  assign last_step = (step_q == STEP_W'(STEPS - 1));

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == ST_IDLE) && start;
    cmd_o.step    = (state_q == ST_DIV);
    cmd_o.first   = (step_q == '0);
    cmd_o.wr_en   = (state_q == ST_DIV) && last_step;
    cmd_o.wr_addr = cnt_q;
    cmd_o.rd_en   = (state_q == ST_EMIT);
    cmd_o.rd_addr = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            step_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (last_step) begin
            step_q <= '0;
            if (sts_i.quot_zero || cnt_q == DIG_AW'(MAX_DIGITS - 1)) begin
              idx_q   <= cnt_q;
              state_q <= ST_EMIT;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_EMIT: begin
          out_valid_q <= 1'b1;
          out_last_q  <= (idx_q == '0);
          if (idx_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe_o = out_valid_q;
  assign last_digit_o = out_last_q;

endmodule

// ===== src/unsigned_to_base_digits_unit.sv =====
// Top level of the unsigned-to-base-digits unit: ties controller and datapath.
// Depends on utd_pkg, utd_ctrl and utd_datapath.
//
// Usage:
//   Request channel: drive value_i and raise start; the request is taken at a
//   clock edge with start high and busy low. busy stays high while the value
//   is being converted and its digits are being sent out.
//   Result channel: each digit appears for exactly one cycle with out_strobe_o
//   high; digit_char_o holds the lower-case ASCII character and last_digit_o
//   marks the least significant, final digit. Digits come most significant
//   first. The receiver cannot stall; nothing holds results back.
//   Configuration: write the radix through cfg_valid_i/cfg_ready_o while the
//   unit is idle. Values below 2 act as 2, values above 16 act as 16.
// Timing:
//   Each digit is produced by the divider, which retires 8 dividend bits a
//   cycle through a remainder chain; once all digits are stored they are read
//   back from the digit store, most significant first. busy drops in the
//   cycle of the last strobe, so the next request can follow right away.
// Reset:
//   rst_ni clears the controller and sets the radix to 16. The digit store
//   needs no clearing: every entry is written before it is read.
module unsigned_to_base_digits_unit
  import utd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [IN_BITS-1:0] value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RADIX_W-1:0] cfg_data_i,
  output logic               out_strobe_o,
  output logic [CHAR_W-1:0]  digit_char_o,
  output logic               last_digit_o
);

  cmd_t cmd;
  sts_t sts;

  // Radix writes are always taken; software must keep them to idle periods, which this block leaves unchecked.
  assign cfg_ready_o = 1'b1;

  utd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .out_strobe_o (out_strobe_o),
    .last_digit_o (last_digit_o)
  );

  utd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .digit_char_o (digit_char_o)
  );

endmodule

// ===== src/utd_checker.sv =====
// Port-level checks for the unsigned-to-base-digits unit, bound to the top.
// Depends on utd_pkg.
module utd_checker
  import utd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              out_strobe_o,
  input logic [CHAR_W-1:0] digit_char_o,
  input logic              last_digit_o
);

  // An accepted request keeps the unit busy until its digits are out.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but unit not busy");

  // Only the final digit may appear once the unit is idle.
  a_mid_digit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !last_digit_o |-> busy)
    else $error("non-final digit while idle");

  // The final digit frees the unit in the same cycle.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_digit_o |-> !busy)
    else $error("unit still busy on final digit");

  // The last flag only rides on a strobed digit.
  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_digit_o |-> out_strobe_o)
    else $error("last flag without strobe");

  // Characters are digits or lower-case a to f.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> ((digit_char_o >= 7'h30 && digit_char_o <= 7'h39) ||
                      (digit_char_o >= 7'h61 && digit_char_o <= 7'h66)))
    else $error("digit character out of range");

endmodule

bind unsigned_to_base_digits_unit utd_checker u_utd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .out_strobe_o (out_strobe_o),
  .digit_char_o (digit_char_o),
  .last_digit_o (last_digit_o)
);
